// ----- hw/rtl/pidc_pkg.sv -----
// Shared widths, register indexes, reset values and saturation helpers for the PID block.
package pidc_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 31;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = DATA_W + GAIN_W;
    localparam int SCL_W     = PROD_W - FRAC_BITS;
    localparam int ACC_W     = SCL_W + 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ITERM_LIM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ISUM_LIM   = 3'd5;

    localparam logic [GAIN_W-1:0] RST_GAIN_P    = 31'd327680;
    localparam logic [GAIN_W-1:0] RST_GAIN_I    = 31'd32768;
    localparam logic [GAIN_W-1:0] RST_GAIN_D    = 31'd26214;
    localparam logic [GAIN_W-1:0] RST_OUT_LIMIT = 31'd131072;
    localparam logic [GAIN_W-1:0] RST_ITERM_LIM = 31'd65536;
    localparam logic [GAIN_W-1:0] RST_ISUM_LIM  = 31'd655360;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [DATA_W:0]   t_data_ext;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [GAIN_W-1:0]        t_gain;

    // Saturate a one-bit-wider difference to the data range.
    function automatic t_data sat_data(input t_data_ext v);
        t_data res;
        if (v[DATA_W] != v[DATA_W-1]) begin
            res = v[DATA_W] ? t_data'({1'b1, {(DATA_W-1){1'b0}}})
                            : t_data'({1'b0, {(DATA_W-1){1'b1}}});
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    // Clamp a one-bit-wider sum to plus or minus an unsigned limit.
    function automatic t_data clamp_data(input t_data_ext v, input t_gain lim);
        t_data_ext lim_s;
        t_data_ext neg_s;
        t_data     res;
        lim_s = $signed({{(DATA_W+1-GAIN_W){1'b0}}, lim});
        neg_s = -lim_s;
        if (v > lim_s) begin
            res = lim_s[DATA_W-1:0];
        end else if (v < neg_s) begin
            res = neg_s[DATA_W-1:0];
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    // Clamp an accumulator-wide value to plus or minus an unsigned limit.
    function automatic t_acc clamp_acc(input t_acc v, input t_gain lim);
        t_acc lim_s;
        t_acc res;
        lim_s = $signed({{(ACC_W-GAIN_W){1'b0}}, lim});
        if (v > lim_s) begin
            res = lim_s;
        end else if (v < -lim_s) begin
            res = -lim_s;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Floor-shift a product by the fraction width and widen to accumulator width.
    function automatic t_acc scale_acc(input logic signed [PROD_W-1:0] p);
        logic signed [SCL_W-1:0] s;
        s = p[PROD_W-1:FRAC_BITS];
        return {{(ACC_W-SCL_W){s[SCL_W-1]}}, s};
    endfunction

endpackage

// ----- hw/rtl/pidc_mul.sv -----
// Registered signed-by-unsigned gain multiplier.
module pidc_mul (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [pidc_pkg::DATA_W-1:0]   i_val,
    input  logic        [pidc_pkg::GAIN_W-1:0]   i_gain,
    output logic signed [pidc_pkg::PROD_W-1:0]   o_prod
);
    import pidc_pkg::*;

    logic signed [2*DATA_W-1:0] n_full;
    logic signed [PROD_W-1:0]   r_prod;

    // Form the exact product; it always fits the narrower signed width.
    assign n_full = i_val * $signed({1'b0, i_gain});

    // Hold the product while the stage is stalled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_full[PROD_W-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- hw/rtl/pid_controller_clamped_top.sv -----
// Top level of the clamped positional PID controller pipeline.
// An accepted request moves through the input, error, product, term and output registers, the
// last driving o_drive. Throughput: one request per cycle while i_stall is low; five pipeline
// stages (input, error/integral update, multiply, term clamp, output clamp), each with its own
// valid bit, so bubbles collapse. Error, derivative difference and integral sum update in one
// stage. Synchronous active-low reset clears valid bits and history and presets configuration.
module pid_controller_clamped_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [pidc_pkg::DATA_W-1:0]    i_target,
    input  logic signed [pidc_pkg::DATA_W-1:0]    i_measured,
    input  logic                                  i_clear_integral,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [pidc_pkg::DATA_W-1:0]    o_drive,
    input  logic                                  i_cfg_we,
    input  logic        [pidc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic        [pidc_pkg::GAIN_W-1:0]    i_cfg_data
);
    import pidc_pkg::*;

    // Configuration registers
    t_gain r_gain_p, r_gain_i, r_gain_d, r_out_lim, r_iterm_lim, r_isum_lim;

    // Controller history
    t_data r_isum, r_prev;

    // Stage valid bits and ready chain
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;

    // Stage 0: input register
    t_data r_tgt, r_meas;
    logic  r_clr;

    // Stage 1: error, difference, integral sum
    t_data r_err, r_diff, r_isum_s;
    t_data n_err, n_diff, n_isum, n_isum_base;

    // Stage 2: products
    logic signed [PROD_W-1:0] w_prod_p, w_prod_i, w_prod_d;

    // Stage 3: clamped integral term and P plus D
    t_acc r_iterm, r_pd;
    t_acc n_iterm, n_pd;

    // Stage 4: output register
    t_data r_drive;
    t_acc  n_total;

    // Advance a stage when it is empty or the next one moves
    assign rdy4    = !r_v4 || !i_stall;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign rdy0    = !r_v0 || rdy1;
    assign o_stall = !rdy0;

    // Write configuration; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= RST_GAIN_P;
            r_gain_i    <= RST_GAIN_I;
            r_gain_d    <= RST_GAIN_D;
            r_out_lim   <= RST_OUT_LIMIT;
            r_iterm_lim <= RST_ITERM_LIM;
            r_isum_lim  <= RST_ISUM_LIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GAIN_P:    r_gain_p    <= i_cfg_data;
                REG_GAIN_I:    r_gain_i    <= i_cfg_data;
                REG_GAIN_D:    r_gain_d    <= i_cfg_data;
                REG_OUT_LIMIT: r_out_lim   <= i_cfg_data;
                REG_ITERM_LIM: r_iterm_lim <= i_cfg_data;
                REG_ISUM_LIM:  r_isum_lim  <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Track valid bits through the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy0) r_v0 <= i_valid;
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_tgt  <= i_target;
            r_meas <= i_measured;
            r_clr  <= i_clear_integral;
        end
    end

    // Form the saturated error, difference and next integral sum
    always_comb begin
        n_err       = sat_data(t_data_ext'(r_tgt) - t_data_ext'(r_meas));
        n_diff      = sat_data(t_data_ext'(n_err) - t_data_ext'(r_prev));
        n_isum_base = r_clr ? '0 : r_isum;
        if (r_gain_i != '0) begin
            n_isum = clamp_data(t_data_ext'(n_isum_base) + t_data_ext'(n_err), r_isum_lim);
        end else begin
            n_isum = n_isum_base;
        end
    end

    // Update history as each request leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isum <= '0;
            r_prev <= '0;
        end else if (r_v0 && rdy1) begin
            r_isum <= n_isum;
            r_prev <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_err    <= n_err;
            r_diff   <= n_diff;
            r_isum_s <= n_isum;
        end
    end

    // Multiply by the three gains
    pidc_mul u_mul_p (
        .i_clk  (i_clk),
        .i_en   (rdy2),
        .i_val  (r_err),
        .i_gain (r_gain_p),
        .o_prod (w_prod_p)
    );

    pidc_mul u_mul_i (
        .i_clk  (i_clk),
        .i_en   (rdy2),
        .i_val  (r_isum_s),
        .i_gain (r_gain_i),
        .o_prod (w_prod_i)
    );

    pidc_mul u_mul_d (
        .i_clk  (i_clk),
        .i_en   (rdy2),
        .i_val  (r_diff),
        .i_gain (r_gain_d),
        .o_prod (w_prod_d)
    );

    // Scale products, clamp the integral term, add P and D
    always_comb begin
        n_iterm = (r_gain_i != '0) ? clamp_acc(scale_acc(w_prod_i), r_iterm_lim) : '0;
        n_pd    = scale_acc(w_prod_p) + scale_acc(w_prod_d);
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_iterm <= n_iterm;
            r_pd    <= n_pd;
        end
    end

    // Sum all terms and saturate the drive
    assign n_total = clamp_acc(r_pd + r_iterm, r_out_lim);

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_drive <= n_total[DATA_W-1:0];
        end
    end

    assign o_valid = r_v4;
    assign o_drive = r_drive;

endmodule
